### hdl/cspe_pkg.sv
// ----------------------------------------------------------------------------
// cspe_pkg
// Shared types and constants for the cubic spline path evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cspe_pkg;

    localparam int COORD_WIDTH_DEF     = 16;
    localparam int PHASE_FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int STEP_W   = 24;
    localparam int TIME_W   = 32;
    localparam int PT_W     = 48;
    localparam int CRD_W    = 16;
    localparam int IN_DW    = 24;
    localparam int OUT_DW   = 64;
    localparam int APB_AW   = 6;
    localparam int APB_DW   = 64;

    // Horner datapath widths
    localparam int EXTRA_W  = 16;
    localparam int COEF_W   = 20;
    localparam int H_W      = 38;
    localparam int HL_W     = 19;

    // Register indexes
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_PERIOD = 3'd1;
    localparam logic [2:0] REG_PT0    = 3'd2;
    localparam logic [2:0] REG_PT1    = 3'd3;
    localparam logic [2:0] REG_PT2    = 3'd4;
    localparam logic [2:0] REG_PT3    = 3'd5;

    localparam logic [TIME_W-1:0] PERIOD_RST = 32'h0001_0000;

    localparam logic MODE_CATMULL = 1'b0;
    localparam logic MODE_BEZIER  = 1'b1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Horner steps after the leading coefficient
    localparam logic [1:0] HSTEP_A2 = 2'd0;
    localparam logic [1:0] HSTEP_A1 = 2'd1;
    localparam logic [1:0] HSTEP_A0 = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_INIT,
        S_MLO,
        S_MHI,
        S_ACC,
        S_RND,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       init;
        logic       mul_lo;
        logic       mul_hi;
        logic       acc;
        logic       rnd;
        logic       out_load;
        logic [1:0] axis;
        logic [1:0] step;
    } t_cmd;

endpackage

`default_nettype wire

### hdl/cspe_regs.sv
// ----------------------------------------------------------------------------
// cspe_regs
// APB register file: curve mode, segment period and four control points.
// ----------------------------------------------------------------------------
`default_nettype none

module cspe_regs
    import cspe_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [APB_AW-1:0]    paddr,
    input  wire [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    output logic                o_mode,
    output logic [TIME_W-1:0]   o_period,
    output logic [PT_W-1:0]     o_pt0,
    output logic [PT_W-1:0]     o_pt1,
    output logic [PT_W-1:0]     o_pt2,
    output logic [PT_W-1:0]     o_pt3
);

    logic       r_mode;
    logic [TIME_W-1:0] r_period;
    logic [PT_W-1:0]   r_pt0, r_pt1, r_pt2, r_pt3;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[APB_AW-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_CATMULL;
            r_period <= PERIOD_RST;
            r_pt0    <= '0;
            r_pt1    <= '0;
            r_pt2    <= '0;
            r_pt3    <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_MODE:   r_mode   <= pwdata[0];
                REG_PERIOD: r_period <= pwdata[TIME_W-1:0];
                REG_PT0:    r_pt0    <= pwdata[PT_W-1:0];
                REG_PT1:    r_pt1    <= pwdata[PT_W-1:0];
                REG_PT2:    r_pt2    <= pwdata[PT_W-1:0];
                REG_PT3:    r_pt3    <= pwdata[PT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MODE:   prdata = {{(APB_DW-1){1'b0}}, r_mode};
            REG_PERIOD: prdata = {{(APB_DW-TIME_W){1'b0}}, r_period};
            REG_PT0:    prdata = {{(APB_DW-PT_W){1'b0}}, r_pt0};
            REG_PT1:    prdata = {{(APB_DW-PT_W){1'b0}}, r_pt1};
            REG_PT2:    prdata = {{(APB_DW-PT_W){1'b0}}, r_pt2};
            REG_PT3:    prdata = {{(APB_DW-PT_W){1'b0}}, r_pt3};
            default:    prdata = '0;
        endcase
    end

    assign o_mode   = r_mode;
    assign o_period = r_period;
    assign o_pt0    = r_pt0;
    assign o_pt1    = r_pt1;
    assign o_pt2    = r_pt2;
    assign o_pt3    = r_pt3;

endmodule

`default_nettype wire

### hdl/cspe_dp.sv
// ----------------------------------------------------------------------------
// cspe_dp
// Datapath: segment timer, restoring divider, shared Horner multiplier,
// rounding/saturation and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module cspe_dp
    import cspe_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_cmd                i_cmd,
    input  wire [STEP_W-1:0]    i_time_step,
    input  wire                 i_mode,
    input  wire [TIME_W-1:0]    i_period,
    input  wire [PT_W-1:0]      i_pt0,
    input  wire [PT_W-1:0]      i_pt1,
    input  wire [PT_W-1:0]      i_pt2,
    input  wire [PT_W-1:0]      i_pt3,
    output logic [OUT_DW-1:0]   o_tdata
);

    localparam int PFB  = PHASE_FRAC_BITS;
    localparam int HH_W = H_W - HL_W;
    localparam int P_W  = H_W + PFB + 1;
    localparam longint SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam longint SAT_LO = -SAT_HI - 64'sd1;

    logic [TIME_W-1:0]          r_elapsed, r_rem;
    logic [PFB-1:0]             r_quot;
    logic signed [H_W-1:0]      r_h;
    logic [HL_W+PFB-1:0]        r_plo;
    logic signed [HH_W+PFB:0]   r_phi;
    logic signed [CRD_W-1:0]    r_px, r_py, r_pz;
    logic [OUT_DW-1:0]          r_tdata;

    logic [TIME_W:0]            sum, rem2, rem_sub;
    logic [TIME_W-1:0]          n_elapsed;
    logic                       q_bit;
    logic signed [CRD_W-1:0]    p0, p1, p2, p3;
    logic signed [COEF_W-1:0]   e0, e1, e2, e3, a0, a1, a2, a3, c_sel;
    logic signed [P_W-1:0]      full;
    logic signed [P_W-1:0]      shifted;
    logic signed [H_W-1:0]      c_ext, lead_ext, rnd_sum, rnd_res;
    logic signed [63:0]         res64;
    logic signed [CRD_W-1:0]    sat;
    logic [15:0]                phase16;

    // Timer and divider
    always_comb begin
        sum       = {1'b0, r_elapsed} + {{(TIME_W + 1 - STEP_W){1'b0}}, i_time_step};
        n_elapsed = (sum >= {1'b0, i_period}) ? '0 : sum[TIME_W-1:0];
        rem2      = {r_rem, 1'b0};
        rem_sub   = rem2 - {1'b0, i_period};
        q_bit     = (i_period != '0) && (rem2 >= {1'b0, i_period});
    end

    // Coordinates of the current axis and curve coefficients
    always_comb begin
        unique case (i_cmd.axis)
            AXIS_Y: begin
                p0 = i_pt0[31:16]; p1 = i_pt1[31:16];
                p2 = i_pt2[31:16]; p3 = i_pt3[31:16];
            end
            AXIS_Z: begin
                p0 = i_pt0[47:32]; p1 = i_pt1[47:32];
                p2 = i_pt2[47:32]; p3 = i_pt3[47:32];
            end
            default: begin
                p0 = i_pt0[15:0]; p1 = i_pt1[15:0];
                p2 = i_pt2[15:0]; p3 = i_pt3[15:0];
            end
        endcase
        e0 = COEF_W'(p0);
        e1 = COEF_W'(p1);
        e2 = COEF_W'(p2);
        e3 = COEF_W'(p3);
        a3 = -e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3;
        if (i_mode == MODE_BEZIER) begin
            a0 = e0;
            a1 = (e1 <<< 1) + e1 - (e0 <<< 1) - e0;
            a2 = (e0 <<< 1) + e0 - (e1 <<< 2) - (e1 <<< 1) + (e2 <<< 1) + e2;
        end else begin
            a0 = e1 <<< 1;
            a1 = e2 - e0;
            a2 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        end
        unique case (i_cmd.step)
            HSTEP_A2: c_sel = a2;
            HSTEP_A1: c_sel = a1;
            default:  c_sel = a0;
        endcase
    end

    // Horner accumulate: floor(h * t) + coefficient
    always_comb begin
        c_ext    = {{(H_W - COEF_W - EXTRA_W){c_sel[COEF_W-1]}}, c_sel, {EXTRA_W{1'b0}}};
        lead_ext = {{(H_W - COEF_W - EXTRA_W){a3[COEF_W-1]}}, a3, {EXTRA_W{1'b0}}};
        full     = $signed({r_phi, {HL_W{1'b0}}}) + $signed({{(HH_W + 1){1'b0}}, r_plo});
        shifted  = full >>> PFB;
    end

    // Round half up to Q8.8, then saturate
    always_comb begin
        if (i_mode == MODE_BEZIER) begin
            rnd_sum = r_h + (H_W'(1) <<< (EXTRA_W - 1));
            rnd_res = rnd_sum >>> EXTRA_W;
        end else begin
            rnd_sum = r_h + (H_W'(1) <<< EXTRA_W);
            rnd_res = rnd_sum >>> (EXTRA_W + 1);
        end
        res64 = {{(64 - H_W){rnd_res[H_W-1]}}, rnd_res};
        if (res64 > SAT_HI)
            sat = CRD_W'(SAT_HI);
        else if (res64 < SAT_LO)
            sat = CRD_W'(SAT_LO);
        else
            sat = res64[CRD_W-1:0];
    end

    generate
        if (PFB >= 16) begin : g_ph_dn
            assign phase16 = r_quot[PFB-1 -: 16];
        end else begin : g_ph_up
            assign phase16 = {r_quot, {(16 - PFB){1'b0}}};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
        end else if (i_cmd.load) begin
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= n_elapsed;
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= q_bit ? rem_sub[TIME_W-1:0] : rem2[TIME_W-1:0];
            r_quot <= {r_quot[PFB-2:0], q_bit};
        end
        if (i_cmd.init)
            r_h <= lead_ext;
        else if (i_cmd.acc)
            r_h <= shifted[H_W-1:0] + c_ext;
        if (i_cmd.mul_lo)
            r_plo <= r_h[HL_W-1:0] * r_quot;
        if (i_cmd.mul_hi)
            r_phi <= $signed(r_h[H_W-1:HL_W]) * $signed({1'b0, r_quot});
        if (i_cmd.rnd) begin
            unique case (i_cmd.axis)
                AXIS_Y:  r_py <= sat;
                AXIS_Z:  r_pz <= sat;
                default: r_px <= sat;
            endcase
        end
        if (i_cmd.out_load)
            r_tdata <= {phase16, r_pz, r_py, r_px};
    end

    assign o_tdata = r_tdata;

endmodule

`default_nettype wire

### hdl/cspe_ctrl.sv
// ----------------------------------------------------------------------------
// cspe_ctrl
// Controller: sequences timer update, division, Horner steps per axis and
// the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module cspe_ctrl
    import cspe_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  wire     i_m_tready,
    output t_cmd    o_cmd
);

    localparam int CNT_W = $clog2(PHASE_FRAC_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PHASE_FRAC_BITS - 1);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0] r_axis, n_axis, r_step, n_step;
    logic r_mvalid, n_mvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_axis   <= AXIS_X;
            r_step   <= HSTEP_A2;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_axis   <= n_axis;
            r_step   <= n_step;
            r_mvalid <= n_mvalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_axis   = r_axis;
        n_step   = r_step;
        n_mvalid = r_mvalid && !i_m_tready;
        o_cmd    = '0;
        o_cmd.axis = r_axis;
        o_cmd.step = r_step;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_axis  = AXIS_X;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_step  = HSTEP_A2;
                n_state = S_MLO;
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_step == HSTEP_A0) begin
                    n_state = S_RND;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_MLO;
                end
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                if (r_axis == AXIS_Z) begin
                    n_state = S_OUT;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_INIT;
                end
            end
            S_OUT: begin
                // hold the finished word until the output register frees up
                if (!r_mvalid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_mvalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_mvalid;

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_DIV))
        else $error("accepted word did not start division");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_mvalid && !i_m_tready) |=> (r_state == S_OUT && r_mvalid))
        else $error("output word overwritten while stalled");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_axis == AXIS_X || r_axis == AXIS_Y || r_axis == AXIS_Z))
        else $error("axis counter out of range");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_step == HSTEP_A2 || r_step == HSTEP_A1 ||
                               r_step == HSTEP_A0))
        else $error("Horner step out of range");

    a_load_after_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> ($past(r_state) == S_RND || $past(r_state) == S_OUT))
        else $error("output loaded before all axes rounded");

endmodule

`default_nettype wire

### hdl/cubic_spline_path_evaluator.sv
// ----------------------------------------------------------------------------
// cubic_spline_path_evaluator
// Segment timer plus Catmull-Rom / Bezier cubic evaluation in x, y and z.
// ----------------------------------------------------------------------------
// One tick word is taken at a time. After its acceptance the timer updates
// on the accepting edge, then the block runs one restoring-division step
// per phase bit, then per axis one load step, three Horner steps (each a
// low-half multiply, a high-half multiply and an accumulate on the shared
// multiplier) and one rounding step, and last it loads the output register
// once that register is free. The next tick word is accepted while the
// previous result still waits on the output side.
`default_nettype none

module cubic_spline_path_evaluator
    import cspe_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  wire [IN_DW-1:0]     i_s_tdata,    // [23:0] time_step
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [OUT_DW-1:0]   o_m_tdata,    // pos_x, pos_y, pos_z, phase
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [APB_AW-1:0]    paddr,
    input  wire [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    t_cmd              cmd;
    logic              mode;
    logic [TIME_W-1:0] period;
    logic [PT_W-1:0]   pt0, pt1, pt2, pt3;

    cspe_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_mode   (mode),
        .o_period (period),
        .o_pt0    (pt0),
        .o_pt1    (pt1),
        .o_pt2    (pt2),
        .o_pt3    (pt3)
    );

    cspe_ctrl #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    cspe_dp #(
        .COORD_WIDTH     (COORD_WIDTH),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_time_step (i_s_tdata[STEP_W-1:0]),
        .i_mode      (mode),
        .i_period    (period),
        .i_pt0       (pt0),
        .i_pt1       (pt1),
        .i_pt2       (pt2),
        .i_pt3       (pt3),
        .o_tdata     (o_m_tdata)
    );

endmodule

`default_nettype wire
